// ----- design/sv32w_pkg.sv -----
// Shared types and constants for the Sv32 page table walker.
`timescale 1ns / 1ps

package sv32w_pkg;

    localparam int VADDR_W   = 32;
    localparam int PADDR_W   = 34;
    localparam int PTE_W     = 32;
    localparam int PPN_W     = 22;
    localparam int VPN_W     = 10;
    localparam int OFFSET_W  = 12;
    localparam int NEEDS_W   = 4;

    // Stream payload widths (fields packed from bit 0, padded to bytes)
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    // PTE flag bit positions
    localparam int PTE_V = 0;
    localparam int PTE_R = 1;
    localparam int PTE_W_BIT = 2;
    localparam int PTE_X = 3;
    localparam int PTE_U = 4;

    // Held permission needs, bit positions
    localparam int NEED_RD = 0;
    localparam int NEED_WR = 1;
    localparam int NEED_EX = 2;
    localparam int NEED_US = 3;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = PPN_W;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRANSLATE_ENABLE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_TABLE_PPN   = 1'b1;

    typedef enum logic {
        OP_REQUEST = 1'b0,
        OP_PTE     = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_READ_PTE = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_FAULT    = 2'd2
    } kind_t;

    typedef struct packed {
        op_t                op;
        logic [VADDR_W-1:0] virt_addr;
        logic [NEEDS_W-1:0] needs;
        logic [PTE_W-1:0]   pte_word;
    } in_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [PADDR_W-1:0] address;
    } result_t;

endpackage

// ----- design/sv32w_in_stage.sv -----
// Input register stage: holds one accepted beat until the walk step consumes it.
`timescale 1ns / 1ps

module sv32w_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  sv32w_pkg::in_item_t s_item,
    input  logic                advance,
    output logic                item_valid,
    output sv32w_pkg::in_item_t item
);
    import sv32w_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- design/sv32w_walk.sv -----
// Walk step: configuration registers, walk state and the per-beat translate logic.
`timescale 1ns / 1ps

module sv32w_walk (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [sv32w_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sv32w_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 fire,
    input  sv32w_pkg::in_item_t                  item,
    output logic                                 has_result,
    output sv32w_pkg::result_t                   result
);
    import sv32w_pkg::*;

    logic               enable_reg;
    logic               enable_next;
    logic [PPN_W-1:0]   root_ppn_reg;
    logic [PPN_W-1:0]   root_ppn_next;

    logic               busy_reg;
    logic               busy_next;
    logic               level_reg;
    logic               level_next;
    logic [VADDR_W-1:0] vaddr_reg;
    logic [VADDR_W-1:0] vaddr_next;
    logic [NEEDS_W-1:0] needs_reg;
    logic [NEEDS_W-1:0] needs_next;

    logic               pte_v;
    logic               pte_r;
    logic               pte_w;
    logic               pte_x;
    logic               pte_u;
    logic [11:0]        pte_ppn1;
    logic [VPN_W-1:0]   pte_ppn0;
    logic               perm_miss;

    always_comb
    begin
        enable_next   = enable_reg;
        root_ppn_next = root_ppn_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_TRANSLATE_ENABLE: enable_next   = cfg_data[0];
                CFG_ROOT_TABLE_PPN:   root_ppn_next = cfg_data;
                default:              enable_next   = enable_reg;
            endcase
        end
    end

    assign pte_v    = item.pte_word[PTE_V];
    assign pte_r    = item.pte_word[PTE_R];
    assign pte_w    = item.pte_word[PTE_W_BIT];
    assign pte_x    = item.pte_word[PTE_X];
    assign pte_u    = item.pte_word[PTE_U];
    assign pte_ppn1 = item.pte_word[31:20];
    assign pte_ppn0 = item.pte_word[19:10];

    assign perm_miss = (needs_reg[NEED_RD] && !pte_r) || (needs_reg[NEED_WR] && !pte_w)
                    || (needs_reg[NEED_EX] && !pte_x) || (needs_reg[NEED_US] && !pte_u);

    always_comb
    begin
        busy_next      = busy_reg;
        level_next     = level_reg;
        vaddr_next     = vaddr_reg;
        needs_next     = needs_reg;
        has_result     = 1'b0;
        result.kind    = KIND_DONE;
        result.address = '0;

        if (fire)
        begin
            if (item.op == OP_REQUEST)
            begin
                if (!busy_reg)
                begin
                    has_result = 1'b1;
                    if (!enable_reg)
                    begin
                        result.kind    = KIND_DONE;
                        result.address = {2'b00, item.virt_addr};
                    end
                    else
                    begin
                        vaddr_next     = item.virt_addr;
                        needs_next     = item.needs;
                        level_next     = 1'b1;
                        busy_next      = 1'b1;
                        result.kind    = KIND_READ_PTE;
                        result.address = {root_ppn_reg, item.virt_addr[31:22], 2'b00};
                    end
                end
            end
            else if (busy_reg)
            begin
                has_result = 1'b1;
                if (!pte_v || (!pte_r && pte_w))
                begin
                    busy_next      = 1'b0;
                    result.kind    = KIND_FAULT;
                    result.address = {2'b00, vaddr_reg};
                end
                else if (!pte_r && !pte_x)
                begin
                    // pointer to the next table
                    if (!level_reg)
                    begin
                        busy_next      = 1'b0;
                        result.kind    = KIND_FAULT;
                        result.address = {2'b00, vaddr_reg};
                    end
                    else
                    begin
                        level_next     = 1'b0;
                        result.kind    = KIND_READ_PTE;
                        result.address = {item.pte_word[31:10], vaddr_reg[21:12], 2'b00};
                    end
                end
                else if (perm_miss || (level_reg && pte_ppn0 != '0))
                begin
                    busy_next      = 1'b0;
                    result.kind    = KIND_FAULT;
                    result.address = {2'b00, vaddr_reg};
                end
                else
                begin
                    busy_next   = 1'b0;
                    result.kind = KIND_DONE;
                    if (level_reg)
                    begin
                        result.address = {pte_ppn1, vaddr_reg[21:12], vaddr_reg[11:0]};
                    end
                    else
                    begin
                        result.address = {pte_ppn1, pte_ppn0, vaddr_reg[11:0]};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            root_ppn_reg <= '0;
            busy_reg     <= 1'b0;
            level_reg    <= 1'b0;
        end
        else
        begin
            enable_reg   <= enable_next;
            root_ppn_reg <= root_ppn_next;
            busy_reg     <= busy_next;
            level_reg    <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vaddr_reg     <= vaddr_next;
        needs_reg     <= needs_next;
    end

`ifndef ASSERT_OFF
    a_ptr_read_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (has_result && result.kind == KIND_READ_PTE) |=> busy_reg)
        else $error("walk not busy after PTE read request");

    a_end_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (has_result && (result.kind == KIND_FAULT || (result.kind == KIND_DONE && busy_reg)))
        |=> !busy_reg)
        else $error("walk still busy after it ended");

    a_idle_pte_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.op == OP_PTE && !busy_reg) |-> !has_result)
        else $error("PTE beat while idle produced a result");

    a_busy_request_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.op == OP_REQUEST && busy_reg) |=> $stable(vaddr_reg) && busy_reg)
        else $error("request during a walk disturbed the walk");

    a_descend_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(level_reg) |-> busy_reg)
        else $error("walk level dropped while idle");
`endif

endmodule

// ----- design/sv32w_out_stage.sv -----
// Result register: holds one result beat until the downstream side takes it.
`timescale 1ns / 1ps

module sv32w_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  sv32w_pkg::result_t result,
    output logic               free,
    output logic               m_tvalid,
    input  logic               m_tready,
    output sv32w_pkg::result_t m_result
);
    import sv32w_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

endmodule

// ----- design/sv32_page_table_walker.sv -----
// Sv32 page table walker: sustains one input beat per clock cycle while the
// output is not stalled. A beat is captured in an input register, translated
// in one pass of flag checks and address concatenation, and its result (if
// any) lands in the result register, which drives the master side. Requests
// start a walk and answer with a level-1 PTE read; PTE beats advance the walk
// to a level-0 read, a physical address or a page fault. Requests during a
// walk and PTE beats while idle are dropped without a result. With
// translate_enable low, requests come back as done with the address
// unchanged. Write configuration only while the walker is idle.
`timescale 1ns / 1ps

module sv32_page_table_walker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // slave side
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [31:0] virt_addr, [32] need_read, [33] need_write, [34] need_exec,
    // [35] need_user, [67:36] pte_word, [71:68] zero
    input  logic [sv32w_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] op
    input  logic                                 s_tuser,
    // master side
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [33:0] address, [39:34] zero
    output logic [sv32w_pkg::M_TDATA_W-1:0]      m_tdata,
    // [1:0] kind
    output logic [1:0]                           m_tuser,
    // configuration write
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sv32w_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sv32w_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sv32w_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    logic     out_free;
    logic     has_result;
    result_t  result;
    result_t  m_result;

    assign s_item.op        = op_t'(s_tuser);
    assign s_item.virt_addr = s_tdata[31:0];
    assign s_item.needs     = s_tdata[35:32];
    assign s_item.pte_word  = s_tdata[67:36];

    // consume the held beat only when the result register can take its result
    assign advance   = item_valid && out_free;
    assign cfg_ready = 1'b1;

    sv32w_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sv32w_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fire       (advance),
        .item       (item),
        .has_result (has_result),
        .result     (result)
    );

    sv32w_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && has_result),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {{(M_TDATA_W - PADDR_W){1'b0}}, m_result.address};
    assign m_tuser = m_result.kind;

endmodule

// ----- tb/sv/sv32w_checker.sv -----
// Checker for the Sv32 walker: follows every beat, predicts the walk and compares results.
`timescale 1ns / 1ps

module sv32w_checker
    import sv32w_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic [1:0]             m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     pending
);

    // Shadow configuration
    logic               paging_on;
    logic [PPN_W-1:0]   root_ppn;

    // Shadow walk state
    logic               busy;
    logic               level;
    logic [VADDR_W-1:0] walk_va;
    logic [NEEDS_W-1:0] walk_needs;
    logic [PADDR_W-1:0] walk_base;

    result_t result_q[$];

    initial
    begin
        mismatches = 0;
        pending    = 0;
        paging_on  = 1'b0;
        root_ppn   = '0;
        busy       = 1'b0;
        level      = 1'b0;
        walk_va    = '0;
        walk_needs = '0;
        walk_base  = '0;
    end

    function automatic bit walk_fault(output result_t res);
        busy        = 1'b0;
        res.kind    = KIND_FAULT;
        res.address = {2'b00, walk_va};
        return 1'b1;
    endfunction

    // Advance the shadow walk by one beat; returns 1 when the beat yields a result.
    function automatic bit walk_step(input in_item_t beat, output result_t res);
        logic [PTE_W-1:0] pte;
        logic             v;
        logic             r;
        logic             w;
        logic             x;
        logic             u;
        logic [9:0]       p0;
        logic [11:0]      p1;
        res = '0;
        if (beat.op == OP_REQUEST)
        begin
            if (busy)
                return 1'b0;
            if (!paging_on)
            begin
                res.kind    = KIND_DONE;
                res.address = {2'b00, beat.virt_addr};
                return 1'b1;
            end
            walk_va     = beat.virt_addr;
            walk_needs  = beat.needs;
            level       = 1'b1;
            busy        = 1'b1;
            walk_base   = {root_ppn, 12'h000};
            res.kind    = KIND_READ_PTE;
            res.address = walk_base + {22'b0, walk_va[31:22], 2'b00};
            return 1'b1;
        end
        if (!busy)
            return 1'b0;
        pte = beat.pte_word;
        v   = pte[PTE_V];
        r   = pte[PTE_R];
        w   = pte[PTE_W_BIT];
        x   = pte[PTE_X];
        u   = pte[PTE_U];
        p0  = pte[19:10];
        p1  = pte[31:20];
        if (!v || (!r && w))
            return walk_fault(res);
        if (!r && !x)
        begin
            if (!level)
                return walk_fault(res);
            level       = 1'b0;
            walk_base   = {pte[31:10], 12'h000};
            res.kind    = KIND_READ_PTE;
            res.address = walk_base + {22'b0, walk_va[21:12], 2'b00};
            return 1'b1;
        end
        if ((walk_needs[NEED_RD] && !r) || (walk_needs[NEED_WR] && !w) ||
            (walk_needs[NEED_EX] && !x) || (walk_needs[NEED_US] && !u))
            return walk_fault(res);
        // superpage must be aligned to 4 MiB
        if (level && p0 != '0)
            return walk_fault(res);
        busy     = 1'b0;
        res.kind = KIND_DONE;
        if (level)
            res.address = {p1, walk_va[21:12], walk_va[11:0]};
        else
            res.address = {p1, p0, walk_va[11:0]};
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : watch
        in_item_t beat;
        result_t  want;
        result_t  got;
        if (rst_n)
        begin
            // pop before push so a stray result never matches a fresh prediction
            if (m_tvalid && m_tready)
            begin
                got.kind    = kind_t'(m_tuser);
                got.address = m_tdata[PADDR_W-1:0];
                if (result_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d address %h", got.kind, got.address);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.kind != want.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                        mismatches = mismatches + 1;
                    end
                    if (got.address != want.address)
                    begin
                        $error("address: expected %h, actual %h", want.address, got.address);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TRANSLATE_ENABLE: paging_on = cfg_data[0];
                    CFG_ROOT_TABLE_PPN:   root_ppn  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                beat.op        = op_t'(s_tuser);
                beat.virt_addr = s_tdata[31:0];
                beat.needs     = s_tdata[35:32];
                beat.pte_word  = s_tdata[67:36];
                if (walk_step(beat, want))
                    result_q.push_back(want);
            end
            pending = result_q.size();
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the walker testbench: clock, reset, stimulus, sink pattern and verdict.
`timescale 1ns / 1ps

module tb_top;
    import sv32w_pkg::*;

    localparam int DRAIN_PAD   = 6;
    localparam int PHASE_BEATS = 125;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int mismatches;
    int pending;
    int burst_left = 0;
    int beats_sent = 0;
    bit paging_on  = 1'b0;

    sv32_page_table_walker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sv32w_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Sink: switch between randomly chosen stall patterns.
    initial
    begin : sink_pattern
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 80);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = 1'($urandom_range(0, 1));
                    2:       m_tready = ($urandom_range(0, 3) == 0);
                    default: m_tready = ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    // Drive one beat at the falling edge and hold it until accepted.
    task automatic send_beat(input op_t op, input logic [31:0] va, input logic [3:0] needs,
                             input logic [31:0] pte);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
            end
            burst_left = $urandom_range(1, 20);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {4'b0000, pte, needs, va};
        do
            @(posedge clk);
        while (!s_tready);
        burst_left = burst_left - 1;
        beats_sent = beats_sent + 1;
    endtask

    task automatic send_request(input logic [31:0] va, input logic [3:0] needs);
        send_beat(OP_REQUEST, va, needs, $urandom());
    endtask

    task automatic send_pte(input logic [31:0] pte);
        send_beat(OP_PTE, $urandom(), 4'($urandom_range(0, 15)), pte);
    endtask

    // Hold off until every prediction has been answered and the pipe is empty.
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_PAD)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == CFG_TRANSLATE_ENABLE)
            paging_on = val[0];
    endtask

    // Leaf PTE that mostly grants what the request needs, sometimes one bit short.
    function automatic logic [31:0] make_leaf(input logic [3:0] needs, input bit superpage);
        logic [31:0] w;
        logic [3:0]  perm;
        w    = $urandom();
        perm = needs | 4'($urandom_range(0, 15));
        if (perm[NEED_WR])
            perm[NEED_RD] = 1'b1;
        if (!perm[NEED_RD] && !perm[NEED_EX])
        begin
            if ($urandom_range(0, 1))
                perm[NEED_RD] = 1'b1;
            else
                perm[NEED_EX] = 1'b1;
        end
        if ($urandom_range(0, 5) == 0)
            perm[$urandom_range(0, 3)] = 1'b0;
        w[PTE_V]   = 1'b1;
        w[4:1]     = perm;
        if (superpage && $urandom_range(0, 4) != 0)
            w[19:10] = '0;
        return w;
    endfunction

    task automatic random_walk();
        logic [31:0] va;
        logic [31:0] ptr;
        logic [3:0]  needs;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            send_beat(op_t'($urandom_range(0, 1)), $urandom(), 4'($urandom_range(0, 15)),
                      $urandom());
            return;
        end
        pick = $urandom_range(0, 9);
        va   = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
        needs = 4'($urandom_range(0, 15));
        send_request(va, needs);
        if (!paging_on)
            return;
        ptr      = $urandom();
        ptr[3:0] = 4'b0001;
        pick     = $urandom_range(0, 99);
        if (pick < 50)
        begin
            send_pte(ptr);
            if ($urandom_range(0, 9) != 0)
                send_pte(($urandom_range(0, 3) != 0) ? make_leaf(needs, 1'b0) : $urandom());
        end
        else if (pick < 85)
            send_pte(make_leaf(needs, 1'b1));
        else if (pick < 95)
            send_pte($urandom());
        // else leave the walk open: the next request is dropped
    endtask

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] en_word;
        logic [PPN_W-1:0]      roots[6];
        bit                    enables[6];
        int                    target;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // pass-through after reset, PTE while idle is dropped
        send_request(32'h0000_0000, 4'h0);
        send_request(32'hFFFF_FFFF, 4'hF);
        send_pte(32'hFFFF_FFFF);
        drain();
        write_reg(CFG_TRANSLATE_ENABLE, 22'h1);
        write_reg(CFG_ROOT_TABLE_PPN, 22'h3F_FFFF);
        // invalid entry, plus a request dropped while busy
        send_request(32'hFFFF_FFFF, 4'hF);
        send_request(32'h0000_0000, 4'h0);
        send_pte(32'h0000_0000);
        // write without read
        send_request(32'h1234_5678, 4'h2);
        send_pte(32'h0000_0005);
        // pointer at level 0
        send_request(32'hFFFF_FFFF, 4'h0);
        send_pte(32'hFFFF_FC01);
        send_pte(32'hFFFF_FC01);
        // two-level walk to a readable page
        send_request(32'h0000_0000, 4'h1);
        send_pte(32'h0000_0001);
        send_pte(32'h0000_0003);
        // leaf lacks the user bit
        send_request(32'hABCD_EF12, 4'hF);
        send_pte(32'h0000_0401);
        send_pte(32'hFFFF_FC0F);
        // misaligned superpage
        send_request(32'h0040_0ABC, 4'h0);
        send_pte(32'h0010_0403);
        // aligned superpage with every permission
        send_request(32'hFFFF_FFFF, 4'hF);
        send_pte(32'hFFF0_001F);
        drain();
        write_reg(CFG_ROOT_TABLE_PPN, 22'h0);
        send_request(32'h0000_0000, 4'h4);
        send_pte(32'h0000_0009);

        enables = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        roots   = '{22'($urandom()), 22'h0, 22'h3F_FFFF, 22'($urandom()),
                    22'($urandom()), 22'($urandom())};
        foreach (roots[i])
        begin
            drain();
            en_word    = CFG_DATA_W'($urandom());
            en_word[0] = enables[i];
            write_reg(CFG_TRANSLATE_ENABLE, en_word);
            write_reg(CFG_ROOT_TABLE_PPN, roots[i]);
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target)
            begin
                random_walk();
                if ($urandom_range(0, 199) == 0)
                    drain();
            end
        end

        drain();
        repeat (10)
            @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
